// File: hw/rtl/fwc_pkg.sv
// Package for the first-in first-out queue with delete-by-value.
// Holds the command codes and the request and response transaction types.
// No dependencies.
package fwc_pkg;

  // Command codes carried in the request transaction.
  typedef enum logic [1:0] {
    CmdEnqueue = 2'd0,
    CmdDequeue = 2'd1,
    CmdDelete  = 2'd2
  } cmd_e;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned OccWidth  = 5;

  // One request transaction.
  typedef struct packed {
    logic [1:0]                  command;
    logic signed [DataWidth-1:0] value;
  } req_t;

  // One response transaction.
  typedef struct packed {
    logic signed [DataWidth-1:0] data_out;
    logic                        was_empty;
    logic                        dropped_full;
    logic                        found;
    logic [OccWidth-1:0]         occupancy;
  } rsp_t;

endpackage

// File: hw/rtl/fwc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used as the entry store of the queue. No dependencies.
module fwc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/fifo_with_cancel_by_value_unit.sv
// Top level of the first-in first-out queue with delete-by-value.
// Depends on fwc_pkg and fwc_ram.
// Enqueue, unused codes and any command on an empty queue: result in the cycle after acceptance.
// Dequeue: busy in StDeqWait while the RAM read completes; the result is registered on leaving it.
// Delete: busy while it visits each held entry (one RAM read per cycle searches, then shifts),
// result in the first cycle with busy low. Results cannot be stalled. Reset empties the queue.
module fifo_with_cancel_by_value_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  fwc_pkg::req_t req_i,
  output logic          done_o,
  output fwc_pkg::rsp_t rsp_o
);

  localparam int unsigned PtrWidth = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntWidth = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrWidth:0]   DepthWide = (PtrWidth + 1)'(QUEUE_DEPTH);
  localparam logic [PtrWidth-1:0] LastPos   = PtrWidth'(QUEUE_DEPTH - 1);
  localparam logic [CntWidth-1:0] FullCnt   = CntWidth'(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    StIdle    = 4'b0001,
    StDeqWait = 4'b0010,
    StSearch  = 4'b0100,
    StShift   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [PtrWidth-1:0] front_q, front_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic [CntWidth-1:0] rem_q, rem_d;
  logic [PtrWidth-1:0] rd_pos_q, rd_pos_d;
  logic [PtrWidth-1:0] wr_pos_q, wr_pos_d;
  logic signed [fwc_pkg::DataWidth-1:0] value_q, value_d;
  logic signed [fwc_pkg::DataWidth-1:0] data_q, data_d;
  logic empty_q, empty_d;
  logic dropped_q, dropped_d;
  logic found_q, found_d;
  logic done_q, done_d;

  logic                          accept;
  logic [PtrWidth:0]             tail_sum;
  logic [PtrWidth-1:0]           tail_pos;
  logic [PtrWidth-1:0]           next_rd_pos;
  logic                          ram_we;
  logic [PtrWidth-1:0]           ram_waddr;
  logic [fwc_pkg::DataWidth-1:0] ram_wdata;
  logic [PtrWidth-1:0]           ram_raddr;
  logic [fwc_pkg::DataWidth-1:0] ram_rdata;
  logic                          match;

  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);
  assign match  = (ram_rdata == value_q);

  // Rear position: front plus count, wrapped by one compare and subtract.
  assign tail_sum = {1'b0, front_q} + (PtrWidth + 1)'(count_q);
  always_comb begin
    if (tail_sum >= DepthWide) begin
      tail_pos = PtrWidth'(tail_sum - DepthWide);
    end else begin
      tail_pos = PtrWidth'(tail_sum);
    end
  end

  // Ring successor of the last read position.
  assign next_rd_pos = (rd_pos_q == LastPos) ? '0 : rd_pos_q + 1'b1;

  // Read address: the front when idle, else the next ring position.
  assign ram_raddr = (state_q == StIdle) ? front_q : next_rd_pos;

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    count_d   = count_q;
    rem_d     = rem_q;
    rd_pos_d  = rd_pos_q;
    wr_pos_d  = wr_pos_q;
    value_d   = value_q;
    data_d    = data_q;
    empty_d   = empty_q;
    dropped_d = dropped_q;
    found_d   = found_q;
    done_d    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = tail_pos;
    ram_wdata = req_i.value;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          value_d   = req_i.value;
          data_d    = '0;
          empty_d   = (count_q == '0);
          dropped_d = 1'b0;
          found_d   = 1'b0;
          case (req_i.command)
            fwc_pkg::CmdEnqueue: begin
              done_d = 1'b1;
              if (count_q == FullCnt) begin
                dropped_d = 1'b1;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            fwc_pkg::CmdDequeue: begin
              if (count_q == '0) begin
                done_d = 1'b1;
              end else begin
                state_d = StDeqWait;
              end
            end
            fwc_pkg::CmdDelete: begin
              if (count_q == '0) begin
                done_d = 1'b1;
              end else begin
                rd_pos_d = front_q;
                rem_d    = count_q - 1'b1;
                state_d  = StSearch;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      StDeqWait: begin
        data_d  = ram_rdata;
        front_d = (front_q == LastPos) ? '0 : front_q + 1'b1;
        count_d = count_q - 1'b1;
        done_d  = 1'b1;
        state_d = StIdle;
      end
      StSearch: begin
        // The entry at rd_pos_q is on the read data now.
        if (match) begin
          found_d = 1'b1;
          if (rem_q != '0) begin
            wr_pos_d = rd_pos_q;
            rd_pos_d = next_rd_pos;
            state_d  = StShift;
          end else begin
            count_d = count_q - 1'b1;
            done_d  = 1'b1;
            state_d = StIdle;
          end
        end else if (rem_q != '0) begin
          rem_d    = rem_q - 1'b1;
          rd_pos_d = next_rd_pos;
        end else begin
          done_d  = 1'b1;
          state_d = StIdle;
        end
      end
      StShift: begin
        // Move the entry just read one place toward the front.
        ram_we    = 1'b1;
        ram_waddr = wr_pos_q;
        ram_wdata = ram_rdata;
        wr_pos_d  = rd_pos_q;
        if (rem_q != CntWidth'(1)) begin
          rem_d    = rem_q - 1'b1;
          rd_pos_d = next_rd_pos;
        end else begin
          count_d = count_q - 1'b1;
          done_d  = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      front_q <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    rd_pos_q  <= rd_pos_d;
    wr_pos_q  <= wr_pos_d;
    value_q   <= value_d;
    data_q    <= data_d;
    empty_q   <= empty_d;
    dropped_q <= dropped_d;
    found_q   <= found_d;
  end

  // Entry store.
  fwc_ram #(
    .Width(fwc_pkg::DataWidth),
    .Depth(QUEUE_DEPTH)
  ) u_entries (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Response transaction.
  assign done_o             = done_q;
  assign rsp_o.data_out     = data_q;
  assign rsp_o.was_empty    = empty_q;
  assign rsp_o.dropped_full = dropped_q;
  assign rsp_o.found        = found_q;
  assign rsp_o.occupancy    = fwc_pkg::OccWidth'(count_q);

  // The count never exceeds the ring size and the front stays inside it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= FullCnt) && (front_q <= LastPos))
    else $error("queue count or front pointer out of range");

  // A dropped enqueue is only reported with the queue full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && dropped_q) |-> (count_q == FullCnt))
    else $error("dropped enqueue reported while not full");

  // A drop and a match never belong to the same transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !(dropped_q && found_q))
    else $error("dropped and found both set");

  // An accepted transaction either completes next cycle or keeps the unit busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (done_q || busy))
    else $error("accepted transaction lost");

  // A successful delete removes exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != StIdle) && (state_d == StIdle) && found_d) |=>
      (count_q == $past(count_q) - 1'b1))
    else $error("delete did not shrink the queue by one");

endmodule
